>>> rtl/lrl_pkg.sv
// Shared types and codes of the recency list.
package lrl_pkg;

	localparam int KEY_W = 64;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;
	localparam int CAP_W = 5;
	localparam int OCC_W = 5;

	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
	localparam logic [OP_W-1:0] OP_REFRESH = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_ABSENT    = 2'd1;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// controller -> datapath commands
	typedef struct packed {
		logic load;   // latch the incoming item
		logic exec;   // apply the operation and load the result register
	} cmd_t;

endpackage

>>> rtl/lru_recency_list_top.sv
// Top level of the recency list: stream ports, controller and datapath.
//
// Ordered list of up to ENTRIES 64-bit keys, oldest first. Each item
// carries an op in s_tuser (lookup, insert, refresh; the unused code acts
// as a lookup) and a key in s_tdata, and yields exactly one result item.
// Lookup only reports presence. Insert appends the key as newest, first
// evicting the oldest key when the list holds at least capacity keys;
// inserting a key already held is ignored with a duplicate status.
// Refresh moves a held key to the newest slot; an absent key is flagged.
// Timing: an item is compared against every entry in the cycle after it
// is accepted (match vector registered); the list update and result
// register load happen in the update step, which also accepts the next
// item. No item is taken during a compare step. A result waiting in the
// output register holds the update step until it is taken, and the next
// item is then accepted only in the cycle that step runs; with nothing
// in flight an item is accepted at once. Capacity is written on the cfg
// channel; the user must write it only while the block is idle, as the
// block does not enforce it. 0 acts as 1 and values above ENTRIES act as
// ENTRIES. Lowering capacity below the current occupancy drops nothing:
// later inserts evict one key each. Key storage has no reset; only
// entries below the occupancy count are ever read.
module lru_recency_list_top #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] key
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [0] hit, [1] evicted_valid, [65:2] evicted_key,
	                               // [67:66] status, [72:68] occupancy, [79:73] zero
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // [4:0] capacity
);

	lrl_pkg::cmd_t                 cmd;
	logic                          hit;
	logic                          evicted_valid;
	logic [lrl_pkg::KEY_W-1:0]     evicted_key;
	logic [lrl_pkg::ST_W-1:0]      status;
	logic [lrl_pkg::OCC_W-1:0]     occupancy;

	// the register is always writable
	assign cfg_ready = 1'b1;

	lrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lrl_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_op         (s_tuser),
		.in_key        (s_tdata),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.hit           (hit),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key),
		.status        (status),
		.occupancy     (occupancy)
	);

	assign m_tdata = {7'd0, occupancy, status, evicted_key, evicted_valid, hit};

	// an accepted item always spends a compare cycle before the next one enters
	a_cmp_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted during compare cycle");

	// each update step produces a visible result
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("update step without result");

	// an eviction only comes from a fresh insert
	a_evict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && evicted_valid |-> !hit && (status == lrl_pkg::ST_OK))
		else $error("eviction on hit or flagged item");

	// a duplicate insert must have found the key
	a_dup_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == lrl_pkg::ST_DUPLICATE) |-> hit)
		else $error("duplicate status without hit");

endmodule

>>> rtl/lrl_ctrl.sv
// Controller: sequences compare and update, owns the result valid flag.
module lrl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output lrl_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       exec_go;
	logic       accept;

	assign out_free = !out_valid_q || m_tready;
	assign exec_go  = (state_q == S_EXEC) && out_free;
	// a new item may enter in the same cycle the previous one retires
	assign s_tready = (state_q == S_IDLE) || exec_go;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	assign cmd.load = accept;
	assign cmd.exec = exec_go;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (exec_go) state_d = accept ? S_CMP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/lrl_dpath.sv
// Datapath: key list with parallel match, shift/append update, result register.
module lrl_dpath #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrl_pkg::cmd_t                 cmd,
	input  logic [lrl_pkg::OP_W-1:0]      in_op,
	input  logic [lrl_pkg::KEY_W-1:0]     in_key,
	input  logic                          cfg_we,
	input  logic [lrl_pkg::CAP_W-1:0]     cfg_data,
	output logic                          hit,
	output logic                          evicted_valid,
	output logic [lrl_pkg::KEY_W-1:0]     evicted_key,
	output logic [lrl_pkg::ST_W-1:0]      status,
	output logic [lrl_pkg::OCC_W-1:0]     occupancy
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);
	localparam int EW = (CW > lrl_pkg::CAP_W) ? CW : lrl_pkg::CAP_W;

	logic [lrl_pkg::KEY_W-1:0] key_list_q [ENTRIES];
	logic [lrl_pkg::KEY_W-1:0] shift_src  [ENTRIES];
	logic [CW-1:0]             held_q;
	logic [lrl_pkg::CAP_W-1:0] cap_q;
	logic [lrl_pkg::OP_W-1:0]  op_q;
	logic [lrl_pkg::KEY_W-1:0] key_q;
	logic [ENTRIES-1:0]        match_q;
	logic [ENTRIES-1:0]        match_d;

	logic                      hit_q;
	logic                      ev_valid_q;
	logic [lrl_pkg::KEY_W-1:0] ev_key_q;
	logic [lrl_pkg::ST_W-1:0]  status_q;
	logic [lrl_pkg::OCC_W-1:0] occ_q;

	logic                      present;
	logic [IW-1:0]             pos;
	logic [lrl_pkg::CAP_W-1:0] cap1;
	logic                      full;
	logic                      is_ins;
	logic                      is_ref;
	logic                      do_evict;
	logic                      do_append;
	logic                      do_move;
	logic                      shift_on;
	logic                      write_on;
	logic [IW-1:0]             start;
	logic [CW-1:0]             last;
	logic [CW-1:0]             wr_idx;
	logic [CW-1:0]             held_next;
	logic [EW-1:0]             held_ext;
	logic [lrl_pkg::ST_W-1:0]  status_d;

	// per-entry compare, masked by occupancy; registered before use
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_d[i] = (key_list_q[i] == key_q) && (CW'(i) < held_q);
		end
	end

	// keys are unique among held entries, so the match is at most one-hot
	always_comb begin
		pos = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_q[i]) pos = pos | IW'(i);
		end
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_src
			if (g < ENTRIES - 1) begin : g_mid
				assign shift_src[g] = key_list_q[g+1];
			end else begin : g_end
				assign shift_src[g] = key_list_q[g];
			end
		end
	endgenerate

	assign present   = |match_q;
	assign cap1      = (cap_q == '0) ? lrl_pkg::CAP_W'(1) : cap_q;
	// held >= min(max(cap,1), ENTRIES)
	assign full      = (EW'(held_q) >= EW'(cap1)) || (held_q == CW'(ENTRIES));
	assign is_ins    = (op_q == lrl_pkg::OP_INSERT);
	assign is_ref    = (op_q == lrl_pkg::OP_REFRESH);
	assign do_evict  = is_ins && !present && full;
	assign do_append = is_ins && !present && !full;
	assign do_move   = is_ref && present;
	assign shift_on  = do_evict || do_move;
	assign write_on  = shift_on || do_append;
	assign start     = do_evict ? '0 : pos;
	assign last      = held_q - CW'(1);
	assign wr_idx    = do_append ? held_q : last;
	assign held_next = do_append ? (held_q + CW'(1)) : held_q;
	assign held_ext  = EW'(held_next);

	always_comb begin
		priority if (is_ins && present) begin
			status_d = lrl_pkg::ST_DUPLICATE;
		end else if (is_ref && !present) begin
			status_d = lrl_pkg::ST_ABSENT;
		end else begin
			status_d = lrl_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		match_q <= match_d;
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
		if (cmd.exec) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (shift_on && (IW'(i) >= start) && (CW'(i) < last)) begin
					key_list_q[i] <= shift_src[i];
				end else if (write_on && (CW'(i) == wr_idx)) begin
					key_list_q[i] <= key_q;
				end
			end
			hit_q      <= present;
			ev_valid_q <= do_evict;
			ev_key_q   <= do_evict ? key_list_q[0] : '0;
			status_q   <= status_d;
			occ_q      <= held_ext[lrl_pkg::OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cap_q  <= lrl_pkg::CAP_RESET;
		end else begin
			if (cmd.exec) held_q <= held_next;
			if (cfg_we) cap_q <= cfg_data;
		end
	end

	assign hit           = hit_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;
	assign status        = status_q;
	assign occupancy     = occ_q;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the LRU recency list: directed and random traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES     = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 24;
	localparam int PHASE_ITEMS = 225;   // 8 random phases, about 1800 items
	localparam int END_SETTLE  = 8;     // settle time after draining, to catch stray result items

	// op code 3 has no function of its own; the block treats it as a lookup
	localparam logic [lrl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	// Result item as it sits in m_tdata; first member is the top bits.
	typedef struct packed {
		logic [6:0]                pad;
		logic [lrl_pkg::OCC_W-1:0] occupancy;
		logic [lrl_pkg::ST_W-1:0]  status;
		logic [lrl_pkg::KEY_W-1:0] ev_key;
		logic                      ev_valid;
		logic                      hit;
	} lrl_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] key
	logic [1:0]  s_tuser;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // [0] hit, [1] evicted_valid, [65:2] evicted_key,
	                        // [67:66] status, [72:68] occupancy, [79:73] zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;  // [4:0] capacity

	lru_recency_list_top #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the list: oldest key at index 0.
	logic [lrl_pkg::KEY_W-1:0] shadow_keys [ENTRIES];
	int                        shadow_count;
	logic [lrl_pkg::CAP_W-1:0] shadow_cap;

	lrl_result_t               pending_results [$];
	logic [lrl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

	int error_count;
	int cycle_count;
	int idle_pct;    // chance per cycle that the sender holds off
	int stall_pct;   // chance per cycle that the result side stalls

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hang or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result-side backpressure, redrawn every cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
		error_count++;
	endtask

	// Checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		lrl_result_t got;
		lrl_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result item", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", 64'(got.hit), 64'(want.hit));
				if (got.ev_valid !== want.ev_valid)
					report_mismatch("evicted_valid", 64'(got.ev_valid), 64'(want.ev_valid));
				if (got.ev_key !== want.ev_key)
					report_mismatch("evicted_key", got.ev_key, want.ev_key);
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.occupancy !== want.occupancy)
					report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
				if (got.pad !== want.pad)
					report_mismatch("padding", 64'(got.pad), 64'(want.pad));
			end
		end
	end

	// Predict the result of one access and update the shadow list.
	function automatic lrl_result_t predict_access(input logic [lrl_pkg::OP_W-1:0] op,
	                                               input logic [lrl_pkg::KEY_W-1:0] key);
		lrl_result_t res;
		int          pos;
		int          cap_eff;
		bit          present;
		res = '0;
		pos = shadow_count;
		for (int i = shadow_count - 1; i >= 0; i--) begin
			if (shadow_keys[i] == key)
				pos = i;   // oldest match wins
		end
		present = (pos < shadow_count);
		cap_eff = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap);
		res.hit    = present;
		res.status = lrl_pkg::ST_OK;
		unique case (op)
			lrl_pkg::OP_INSERT: begin
				if (present) begin
					res.status = lrl_pkg::ST_DUPLICATE;
				end else begin
					// full, or over a lowered capacity: drop the oldest first
					if (shadow_count >= cap_eff && shadow_count > 0) begin
						res.ev_valid = 1'b1;
						res.ev_key   = shadow_keys[0];
						for (int i = 0; i + 1 < shadow_count; i++)
							shadow_keys[i] = shadow_keys[i + 1];
						shadow_count--;
					end
					if (shadow_count < ENTRIES) begin
						shadow_keys[shadow_count] = key;
						shadow_count++;
					end
				end
			end
			lrl_pkg::OP_REFRESH: begin
				if (present) begin
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_keys[i] = shadow_keys[i + 1];
					shadow_keys[shadow_count - 1] = key;
				end else begin
					res.status = lrl_pkg::ST_ABSENT;
				end
			end
			default: begin
				// lookup and the unused code leave the list alone
			end
		endcase
		res.occupancy = shadow_count[lrl_pkg::OCC_W-1:0];
		return res;
	endfunction

	// Send one item with random sender gaps; predict it once accepted.
	task automatic send_item(input logic [lrl_pkg::OP_W-1:0] op,
	                         input logic [lrl_pkg::KEY_W-1:0] key);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= 2'($urandom);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_access(op, key));
	endtask

	// Hold the input side off until every expected result has come back.
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Capacity is only written with the block idle.
	task automatic write_capacity(input logic [lrl_pkg::CAP_W-1:0] value);
		wait_results_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_cap = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [lrl_pkg::OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return lrl_pkg::OP_LOOKUP;
		else if (r < 65)
			return lrl_pkg::OP_INSERT;
		else if (r < 95)
			return lrl_pkg::OP_REFRESH;
		return OP_UNUSED;
	endfunction

	// Mostly keys already held or from a small pool, so hits are common.
	function automatic logic [lrl_pkg::KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 30 && shadow_count > 0)
			return shadow_keys[$urandom_range(shadow_count - 1)];
		else if (r < 80)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	// Empty list after reset: misses, absent refresh, unused op code.
	task automatic test_empty_list();
		send_item(lrl_pkg::OP_LOOKUP, '0);
		send_item(lrl_pkg::OP_REFRESH, '1);
		send_item(OP_UNUSED, '0);
	endtask

	// Inserts, a duplicate insert, hits, and a refresh that reorders.
	task automatic test_insert_refresh();
		send_item(lrl_pkg::OP_INSERT, '0);
		send_item(lrl_pkg::OP_INSERT, '1);
		send_item(lrl_pkg::OP_INSERT, '0);
		send_item(lrl_pkg::OP_LOOKUP, '1);
		send_item(lrl_pkg::OP_REFRESH, '0);      // all-ones becomes oldest
		send_item(OP_UNUSED, '1);
	endtask

	// Eviction at a small capacity, then capacity 0 below the occupancy.
	task automatic test_small_capacity();
		write_capacity(5'd2);
		send_item(lrl_pkg::OP_INSERT, key_pool[2]);   // evicts all-ones
		write_capacity(5'd0);                         // acts as 1, two keys still held
		send_item(lrl_pkg::OP_INSERT, key_pool[3]);
		send_item(lrl_pkg::OP_INSERT, key_pool[4]);
		send_item(lrl_pkg::OP_LOOKUP, key_pool[3]);
	endtask

	// Capacity above the list size saturates; refresh hit and miss.
	task automatic test_capacity_saturation();
		write_capacity(5'd31);
		send_item(lrl_pkg::OP_INSERT, key_pool[5]);
		send_item(lrl_pkg::OP_INSERT, key_pool[6]);
		send_item(lrl_pkg::OP_REFRESH, key_pool[4]);
		send_item(lrl_pkg::OP_REFRESH, key_pool[7]);
		send_item(lrl_pkg::OP_LOOKUP, key_pool[5]);
	endtask

	// Random traffic in phases of capacity and handshake pressure.
	task automatic test_random_traffic();
		int caps  [8] = '{16, 1, 5, 17, 3, 31, 0, 8};
		int idles [4] = '{0, 50, 0, 19};
		int stalls[4] = '{0, 0, 50, 19};
		for (int ph = 0; ph < 8; ph++) begin
			write_capacity(caps[ph][lrl_pkg::CAP_W-1:0]);
			idle_pct  = idles[ph % 4];
			stall_pct = stalls[ph % 4];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					wait_results_drained();   // sender pause until all results are back
				send_item(pick_op(), pick_key());
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = lrl_pkg::OP_LOOKUP;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		error_count  = 0;
		cycle_count  = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		shadow_count = 0;
		shadow_cap   = lrl_pkg::CAP_RESET;
		foreach (shadow_keys[i])
			shadow_keys[i] = '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_insert_refresh();
		test_small_capacity();
		test_capacity_saturation();
		test_random_traffic();

		// everything sent: wait out the results, then catch stray items
		wait_results_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
